[hw/rtl/ssic_pkg.sv]
// ssic_pkg: widths, operation and status codes, controller states
// for the sorted set intersection counter. No dependencies.

package ssic_pkg;

  localparam int SET_DEPTH = 256;
  localparam int KEY_W     = 32;
  localparam int ADDR_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int SIZE_W    = $clog2(SET_DEPTH + 1);
  localparam int COUNT_W   = 9;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_INS_A = 2'd0,
    OP_INS_B = 2'd1,
    OP_CLEAR = 2'd2,
    OP_COUNT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_PROBE,
    S_SHIFT,
    S_CNT_RD,
    S_CNT_CMP,
    S_DONE
  } state_t;

endpackage

[hw/rtl/sorted_set_intersection_count.sv]
// sorted_set_intersection_count: two sorted key sets held in on-chip RAM,
// insert with duplicate/full detection, clear, and merge-walk shared count.
// Depends on ssic_pkg.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: operation; tdata: key
//  m_*     | out | m_tvalid/m_tready  | tdata: status, shared_count
//
// One request at a time. Insert: a lower-bound search of p probes (one RAM
// read and one compare each, p <= ceil(log2(n+1))), then the shift, which
// moves the entries from pos up by one and writes the key into its slot;
// duplicate and full skip the shift. Clear empties both sets. Count: a merge
// walk over both sets, one RAM read and one compare per step. The RAM read
// latency is why each probe and merge step has its own read state. Reset
// (synchronous) empties both sets; RAM contents are not cleared. A stalled
// result sits in the output register while the next request is taken; that
// request finishes once it drains.

module sorted_set_intersection_count
  import ssic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] key
  input  logic [1:0]            s_tuser,   // [1:0] operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [1:0] status, [10:2] shared_count
);

  state_t state, state_next;

  // key RAMs
  logic [KEY_W-1:0]  mem_a [SET_DEPTH];
  logic [KEY_W-1:0]  mem_b [SET_DEPTH];
  logic              a_we, b_we;
  logic [ADDR_W-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [KEY_W-1:0]  a_wdata, b_wdata, a_rdata, b_rdata;

  // set sizes and working registers
  logic [SIZE_W-1:0]  size_a, size_b;
  op_t                op_q;
  logic [KEY_W-1:0]   key_q;
  logic [SIZE_W-1:0]  lo, hi, mid_q, cnt, idx_i, idx_j;
  logic               dup;
  logic               pend;
  logic [ADDR_W-1:0]  pend_addr;
  status_t            st_q;
  logic [COUNT_W-1:0] match;

  // output register
  logic               res_valid;
  status_t            res_status;
  logic [COUNT_W-1:0] res_count;

  logic               in_acc, out_free, sel_b;
  logic [SIZE_W-1:0]  n_sel, cnt_m1;
  logic [SIZE_W:0]    mid_sum;
  logic [SIZE_W-1:0]  mid;
  logic [KEY_W-1:0]   srch_data;
  op_t                op_in;

  assign op_in     = op_t'(s_tuser);
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !res_valid || m_tready;
  assign sel_b     = (op_q == OP_INS_B);
  assign n_sel     = sel_b ? size_b : size_a;
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[SIZE_W:1];
  assign cnt_m1    = cnt - SIZE_W'(1);
  assign srch_data = sel_b ? b_rdata : a_rdata;

  assign m_tvalid = res_valid;
  assign m_tdata  = {(OUT_DATA_W-COUNT_W-2)'(0), res_count, res_status};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (op_in)
            OP_INS_A, OP_INS_B: state_next = S_SRCH;
            OP_COUNT:           state_next = S_CNT_RD;
            default:            state_next = S_DONE;
          endcase
        end
      end
      S_SRCH: begin
        if (lo < hi)                                state_next = S_PROBE;
        else if (dup || n_sel == SIZE_W'(SET_DEPTH)) state_next = S_DONE;
        else                                        state_next = S_SHIFT;
      end
      S_PROBE:   state_next = S_SRCH;
      S_SHIFT:   if (cnt == lo && !pend) state_next = S_DONE;
      S_CNT_RD:  state_next = (idx_i < size_a && idx_j < size_b) ? S_CNT_CMP : S_DONE;
      S_CNT_CMP: state_next = S_CNT_RD;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs: handshake and RAM ports
  always_comb begin
    s_tready = (state == S_IDLE);
    a_we     = 1'b0;
    b_we     = 1'b0;
    a_waddr  = pend_addr;
    b_waddr  = pend_addr;
    a_wdata  = a_rdata;
    b_wdata  = b_rdata;
    a_raddr  = idx_i[ADDR_W-1:0];
    b_raddr  = idx_j[ADDR_W-1:0];
    case (state)
      S_SRCH: begin
        a_raddr = mid[ADDR_W-1:0];
        b_raddr = mid[ADDR_W-1:0];
      end
      S_SHIFT: begin
        a_raddr = cnt_m1[ADDR_W-1:0];
        b_raddr = cnt_m1[ADDR_W-1:0];
        if (pend) begin
          // move the entry read last cycle up by one
          a_we = !sel_b;
          b_we = sel_b;
        end else if (cnt == lo) begin
          // shift finished: drop the new key into its slot
          a_we    = !sel_b;
          b_we    = sel_b;
          a_waddr = lo[ADDR_W-1:0];
          b_waddr = lo[ADDR_W-1:0];
          a_wdata = key_q;
          b_wdata = key_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    a_rdata <= mem_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[b_waddr] <= b_wdata;
    b_rdata <= mem_b[b_raddr];
  end

  // control and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      size_a    <= '0;
      size_b    <= '0;
      res_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state <= state_next;
      // in DONE the output register is reloaded below instead
      if (res_valid && m_tready && state != S_DONE) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_q  <= op_in;
            key_q <= s_tdata[KEY_W-1:0];
            lo    <= '0;
            hi    <= (op_in == OP_INS_B) ? size_b : size_a;
            dup   <= 1'b0;
            idx_i <= '0;
            idx_j <= '0;
            match <= '0;
            st_q  <= ST_OK;
            pend  <= 1'b0;
            if (op_in == OP_CLEAR) begin
              size_a <= '0;
              size_b <= '0;
            end
          end
        end
        S_SRCH: begin
          mid_q <= mid;
          if (!(lo < hi)) begin
            cnt <= n_sel;
            if (dup)                              st_q <= ST_DUP;
            else if (n_sel == SIZE_W'(SET_DEPTH)) st_q <= ST_FULL;
          end
        end
        S_PROBE: begin
          // lower-bound search; any equal probe means the key is present
          if (srch_data == key_q) dup <= 1'b1;
          if (srch_data < key_q) lo <= mid_q + SIZE_W'(1);
          else                   hi <= mid_q;
        end
        S_SHIFT: begin
          if (cnt != lo) begin
            pend      <= 1'b1;
            pend_addr <= cnt[ADDR_W-1:0];
            cnt       <= cnt_m1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (sel_b) size_b <= size_b + SIZE_W'(1);
              else       size_a <= size_a + SIZE_W'(1);
            end
          end
        end
        S_CNT_CMP: begin
          if (a_rdata < b_rdata) begin
            idx_i <= idx_i + SIZE_W'(1);
          end else if (b_rdata < a_rdata) begin
            idx_j <= idx_j + SIZE_W'(1);
          end else begin
            if (match != '1) match <= match + COUNT_W'(1);
            idx_i <= idx_i + SIZE_W'(1);
            idx_j <= idx_j + SIZE_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_valid  <= 1'b1;
            res_status <= st_q;
            res_count  <= (op_q == OP_COUNT) ? match : '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[bench/ssic_checker.sv]
// ssic_checker: watches both stream channels of the sorted set intersection
// counter, keeps its own copy of the two key sets and checks every result.
// Depends on ssic_pkg.

module ssic_checker
  import ssic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] key
  input  logic [1:0]            s_tuser,   // [1:0] operation
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] status, [10:2] shared_count
  output int                    outstanding,
  output int                    mismatches
);

  localparam int COUNT_LIMIT = (1 << COUNT_W) - 1;
  localparam int PRINT_CAP   = 100;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   shared;
  } result_t;

  // index 0 is set A, index 1 set B; each kept ascending
  logic [KEY_W-1:0] held_keys [2][$];
  result_t          due_results [$];
  int               fail_count = 0;

  assign mismatches = fail_count;

  task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
    if (fail_count < PRINT_CAP)
      $display("%0t mismatch %s: got %0h, expected %0h", $time, what, seen, wanted);
    fail_count++;  // beyond the cap mismatches are only counted
  endtask

  // merge walk over both sets
  function automatic logic [COUNT_W-1:0] shared_keys();
    int i = 0;
    int j = 0;
    int hits = 0;
    int na = held_keys[0].size();
    int nb = held_keys[1].size();
    while (i < na && j < nb) begin
      if (held_keys[0][i] < held_keys[1][j]) begin
        i++;
      end else if (held_keys[1][j] < held_keys[0][i]) begin
        j++;
      end else begin
        hits++;
        i++;
        j++;
      end
    end
    if (hits > COUNT_LIMIT) hits = COUNT_LIMIT;
    return hits[COUNT_W-1:0];
  endfunction

  task automatic apply_request(input op_t op, input logic [KEY_W-1:0] key,
                               output result_t res);
    int side;
    int pos;
    int n;
    res.status = ST_OK;
    res.shared = '0;
    case (op)
      OP_INS_A, OP_INS_B: begin
        side = (op == OP_INS_B) ? 1 : 0;
        n    = held_keys[side].size();
        pos  = 0;
        while (pos < n && held_keys[side][pos] < key) pos++;
        // a duplicate wins over a full set
        if (pos < n && held_keys[side][pos] == key) res.status = ST_DUP;
        else if (n >= SET_DEPTH)                    res.status = ST_FULL;
        else                                        held_keys[side].insert(pos, key);
      end
      OP_CLEAR: begin
        held_keys[0].delete();
        held_keys[1].delete();
      end
      default: res.shared = shared_keys();
    endcase
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      held_keys[0].delete();
      held_keys[1].delete();
      due_results.delete();
      outstanding <= 0;
    end else begin
      // take the request first: a result leaving now always belongs to an older one
      if (s_tvalid && s_tready) begin
        apply_request(op_t'(s_tuser), s_tdata[KEY_W-1:0], want);
        due_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tdata[1:0]);
        got.shared = m_tdata[2 +: COUNT_W];
        if (due_results.size() == 0) begin
          report_mismatch("result with no request outstanding", 32'(m_tdata), '0);
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.shared !== want.shared)
            report_mismatch("shared_count", 32'(got.shared), 32'(want.shared));
        end
      end
      outstanding <= due_results.size();
    end
  end

endmodule

[bench/testbench.sv]
// testbench: stimulus and verdict for sorted_set_intersection_count.
// Depends on ssic_pkg, the block itself and ssic_checker.

module testbench;
  import ssic_pkg::*;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [31:0] key
  logic [1:0]            s_tuser  = '0;   // [1:0] operation
  logic                  m_tready = 1'b0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;         // [1:0] status, [10:2] shared_count
  int                    outstanding;
  int                    mismatches;
  bit                    steady = 1'b0;   // high: neither side idles

  sorted_set_intersection_count dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ssic_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: stalls roughly one cycle in five, never inside the steady stretch
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 20);
  end

  // hard stop; the slowest correct run is well under a fifth of this
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Offer one request and hold it until taken. A gap first lowers valid for a
  // random stretch; otherwise valid stays high straight into the next request.
  task automatic send_request(op_t op, logic [KEY_W-1:0] key);
    if (!steady && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= key;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // sender holds off until every result owed has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Fill one set to the brim with base .. base+255 in shuffled order, with
  // counts and repeated keys sprinkled in, then knock on the full set.
  task automatic fill_set(op_t op, logic [KEY_W-1:0] base);
    int order [SET_DEPTH];
    int pick;
    int tmp;
    int roll;
    for (int i = 0; i < SET_DEPTH; i++) order[i] = i;
    for (int i = SET_DEPTH - 1; i > 0; i--) begin
      pick        = $urandom_range(0, i);
      tmp         = order[i];
      order[i]    = order[pick];
      order[pick] = tmp;
    end
    for (int i = 0; i < SET_DEPTH; i++) begin
      steady <= (op == OP_INS_A) && i >= 40 && i < 140;
      roll = $urandom_range(0, 99);
      if (roll < 3)
        send_request(OP_COUNT, $urandom);
      else if (roll < 6 && i > 0)
        send_request(op, base + order[$urandom_range(0, i - 1)]);
      send_request(op, base + order[i]);
    end
    steady <= 1'b0;
    send_request(op, base + SET_DEPTH);      // full: above the range
    send_request(op, base - 1);              // full: below the range
    send_request(op, base + order[0]);       // repeat into a full set
    send_request(op, base + SET_DEPTH - 1);  // repeat of the top key
    send_request(OP_COUNT, $urandom);
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] key;
    op_t              op;
    int               roll;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty sets, key extremes, duplicates, disjoint ranges both ways
    send_request(OP_COUNT, 32'hFFFF_FFFF);   // both empty
    send_request(OP_INS_A, 32'h0000_0000);
    send_request(OP_COUNT, 32'h0000_0000);   // B empty
    send_request(OP_INS_B, 32'hFFFF_FFFF);
    send_request(OP_COUNT, 32'h1234_5678);   // A entirely below B
    send_request(OP_INS_A, 32'hFFFF_FFFF);
    send_request(OP_INS_A, 32'hFFFF_FFFF);   // duplicate in A
    send_request(OP_INS_B, 32'h0000_0000);
    send_request(OP_INS_B, 32'h0000_0000);   // duplicate in B
    send_request(OP_INS_A, 32'h8000_0000);
    send_request(OP_INS_B, 32'h7FFF_FFFF);
    send_request(OP_COUNT, 32'h0);
    send_request(OP_INS_A, 32'h5555_5555);
    send_request(OP_INS_B, 32'hAAAA_AAAA);
    send_request(OP_COUNT, 32'h0);
    send_request(OP_CLEAR, 32'hFFFF_FFFF);
    send_request(OP_COUNT, 32'h0);           // empty again after clear
    send_request(OP_INS_B, 32'd5);
    send_request(OP_INS_B, 32'd3);
    send_request(OP_INS_A, 32'd10);
    send_request(OP_INS_A, 32'd9);
    send_request(OP_COUNT, 32'h0);           // B entirely below A
    send_request(OP_INS_A, 32'd3);
    send_request(OP_COUNT, 32'h0);
    send_request(OP_CLEAR, 32'h0);
    wait_drained();

    // both sets full, B shifted against A so the overlap is 256 - shift
    base = $urandom;
    fill_set(OP_INS_A, base);
    fill_set(OP_INS_B, base + $urandom_range(0, 64));
    wait_drained();
    send_request(OP_CLEAR, $urandom);

    // short mixed runs over narrow key windows so repeats and shared keys are common
    for (int phase = 0; phase < 2; phase++) begin
      base = $urandom;
      repeat (15) begin
        roll = $urandom_range(0, 99);
        key  = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 15);
        op   = (roll < 35) ? OP_INS_A :
               (roll < 70) ? OP_INS_B :
               (roll < 92) ? OP_COUNT : OP_CLEAR;
        send_request(op, key);
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ssic_pkg.sv
hw/rtl/sorted_set_intersection_count.sv
bench/ssic_checker.sv
bench/testbench.sv
